// ===== sv/clnws_pkg.sv =====
// Shared types, constants and helpers for the character LCD nibble write sequencer.
package clnws_pkg;

  // Width of the wait and pulse counter.
  localparam int TimerWidth = 16;
  localparam logic [31:0] CountMax = 32'((64'd1 << TimerWidth) - 64'd1);

  // Depth of the queue between the front and the back.
  localparam int FifoDepth = 2;

  localparam int CfgWidth = 16;
  localparam int CfgIndexWidth = 2;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_PULSE  = 2'd0,
    CFG_SETTLE = 2'd1,
    CFG_POWER  = 2'd2,
    CFG_CLEAR  = 2'd3
  } cfg_index_e;

  localparam logic [CfgWidth-1:0] PulseReset  = 16'd100;
  localparam logic [CfgWidth-1:0] SettleReset = 16'd2000;
  localparam logic [CfgWidth-1:0] PowerReset  = 16'd10000;
  localparam logic [CfgWidth-1:0] ClearReset  = 16'd20000;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_INIT = 2'd1,
    OP_CMD  = 2'd2,
    OP_CHAR = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] byte_value;
    logic [7:0] cursor_code;
  } item_t;

  localparam int InitCount = 5;

  // Power-up command sequence for 4-bit, two-line operation.
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h32;
      3'd2:    b = 8'h28;
      3'd3:    b = 8'h0C;
      3'd4:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] mirror4(input logic [3:0] n);
    return {n[0], n[1], n[2], n[3]};
  endfunction

endpackage

// ===== sv/char_lcd_nibble_write_sequencer.sv =====
// Top level of the character LCD nibble write sequencer.

// Every input transfer is a one-microsecond tick or a request (init, command byte,
// character at cursor) and yields exactly one result transfer carrying the pin levels,
// busy flag and a reject flag for requests that arrive while a sequence runs. The block
// takes one item per cycle unless the stalled output holds it back; each item passes the
// front register and the two-entry queue, and the back end update then writes its result,
// and the back end updates its state once for every item that it takes.
// A stalled output holds its result while up to three further items are buffered.
// Configuration writes take effect at once and are meant for idle periods only.
module char_lcd_nibble_write_sequencer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [clnws_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [clnws_pkg::CfgWidth-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [7:0]                          byte_value_i,
  input  logic [7:0]                          cursor_code_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [3:0]                          data_pins_o,
  output logic                                reg_select_o,
  output logic                                read_write_o,
  output logic                                enable_o,
  output logic                                busy_res_o,
  output logic                                rejected_o
);
  import clnws_pkg::*;

  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  clnws_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .byte_value_i  (byte_value_i),
    .cursor_code_i (cursor_code_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  clnws_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  clnws_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_item_i   (pop_item),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_pins_o  (data_pins_o),
    .reg_select_o (reg_select_o),
    .enable_o     (enable_o),
    .busy_res_o   (busy_res_o),
    .rejected_o   (rejected_o)
  );

  // The bus is write only.
  assign read_write_o = 1'b0;

  // A request is only rejected while a sequence is running, which leaves it running.
  a_reject_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> busy_res_o)
    else $error("rejected result without busy");

  // The enable strobe is only raised inside a running sequence.
  a_enable_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && enable_o |-> busy_res_o)
    else $error("enable high while idle");

  // The front register only stalls when the queue toward the back end is full.
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> push_valid && !push_ready)
    else $error("input stalled with room in the queue");

endmodule

// ===== sv/clnws_front.sv =====
// Front stage: takes input transfers, classifies them and pushes them into the queue.
module clnws_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             command_i,
  input  logic [7:0]             byte_value_i,
  input  logic [7:0]             cursor_code_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output clnws_pkg::item_t       push_item_o
);
  import clnws_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  assign in_stall_o = valid_q && !push_ready_i;
  assign take = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (valid_q && push_ready_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d = 1'b1;
      unique case (command_i)
        2'd0:    item_d.op = OP_TICK;
        2'd1:    item_d.op = OP_INIT;
        2'd2:    item_d.op = OP_CMD;
        default: item_d.op = OP_CHAR;
      endcase
      item_d.byte_value  = byte_value_i;
      item_d.cursor_code = cursor_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

endmodule

// ===== sv/clnws_fifo.sv =====
// Short queue that decouples the front stage from the sequencing back end.
module clnws_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  clnws_pkg::item_t push_item_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output clnws_pkg::item_t pop_item_o
);
  import clnws_pkg::*;

  localparam int PtrWidth = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntWidth = $clog2(FifoDepth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(FifoDepth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(FifoDepth);

  item_t               entries_q [FifoDepth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_item_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== sv/clnws_back.sv =====
// Back end: configuration registers, the LCD sequencing state and the result register.
module clnws_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [clnws_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [clnws_pkg::CfgWidth-1:0]       cfg_wdata_i,
  input  logic                                 pop_valid_i,
  output logic                                 pop_ready_o,
  input  clnws_pkg::item_t                     pop_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [3:0]                           data_pins_o,
  output logic                                 reg_select_o,
  output logic                                 enable_o,
  output logic                                 busy_res_o,
  output logic                                 rejected_o
);
  import clnws_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_POWER,
    PH_PULSE,
    PH_SETTLE,
    PH_CLEAR
  } phase_e;

  // Advances the counter by one tick; the top bit flags that the limit is reached.
  function automatic logic [TimerWidth:0] count_step(input logic [TimerWidth-1:0] cnt,
                                                     input logic [CfgWidth-1:0]   limit,
                                                     input logic                  at_least_one);
    logic [31:0] lim;
    logic [31:0] nxt;
    lim = 32'(limit);
    if (lim > CountMax) begin
      lim = CountMax;
    end
    if (at_least_one && lim == 32'd0) begin
      lim = 32'd1;
    end
    nxt = 32'(cnt);
    if (nxt < CountMax) begin
      nxt = nxt + 32'd1;
    end
    return {(nxt >= lim), nxt[TimerWidth-1:0]};
  endfunction

  logic [CfgWidth-1:0] pulse_q, settle_q, power_q, clear_q;

  phase_e                phase_q, phase_d;
  logic [TimerWidth-1:0] tick_q, tick_d;
  logic [7:0]            cur_byte_q, cur_byte_d, queued_q, queued_d;
  logic                  char_wait_q, char_wait_d, low_next_q, low_next_d;
  logic                  sel_q, sel_d, strobe_q, strobe_d;
  logic [2:0]            init_idx_q, init_idx_d;
  logic [3:0]            pin_q, pin_d;

  logic                  out_valid_q;
  logic                  rejected_q, busy_q;
  logic                  rej;
  logic                  pop;

  logic                  sb_en, sb_rs, sn_low;
  logic [7:0]            sb_byte;
  logic [TimerWidth:0]   step;

  assign pop_ready_o = !out_valid_q || !out_stall_i;
  assign pop = pop_valid_i && pop_ready_o;

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    cur_byte_d  = cur_byte_q;
    queued_d    = queued_q;
    char_wait_d = char_wait_q;
    low_next_d  = low_next_q;
    sel_d       = sel_q;
    strobe_d    = strobe_q;
    init_idx_d  = init_idx_q;
    pin_d       = pin_q;
    rej         = 1'b0;
    sb_en       = 1'b0;
    sb_rs       = 1'b0;
    sb_byte     = 8'h00;
    sn_low      = 1'b0;
    step        = '0;

    unique case (pop_item_i.op)
      OP_TICK: begin
        unique case (phase_q)
          PH_POWER: begin
            step   = count_step(tick_q, power_q, 1'b0);
            tick_d = step[TimerWidth-1:0];
            if (step[TimerWidth]) begin
              init_idx_d = 3'd1;
              sb_en      = 1'b1;
              sb_byte    = init_byte(3'd0);
            end
          end
          PH_PULSE: begin
            step   = count_step(tick_q, pulse_q, 1'b1);
            tick_d = step[TimerWidth-1:0];
            if (step[TimerWidth]) begin
              strobe_d = 1'b0;
              tick_d   = '0;
              phase_d  = PH_SETTLE;
            end
          end
          PH_SETTLE: begin
            step   = count_step(tick_q, settle_q, 1'b1);
            tick_d = step[TimerWidth-1:0];
            if (step[TimerWidth]) begin
              if (low_next_q) begin
                sn_low = 1'b1;
              end else if (char_wait_q) begin
                // The character byte follows its cursor command.
                char_wait_d = 1'b0;
                sb_en       = 1'b1;
                sb_rs       = 1'b1;
                sb_byte     = queued_q;
              end else if (init_idx_q >= 3'd1 && init_idx_q < 3'(InitCount)) begin
                sb_en      = 1'b1;
                sb_byte    = init_byte(init_idx_q);
                init_idx_d = init_idx_q + 3'd1;
              end else if (init_idx_q >= 3'(InitCount)) begin
                init_idx_d = '0;
                tick_d     = '0;
                phase_d    = (clear_q == '0) ? PH_IDLE : PH_CLEAR;
              end else begin
                phase_d = PH_IDLE;
              end
            end
          end
          PH_CLEAR: begin
            step   = count_step(tick_q, clear_q, 1'b0);
            tick_d = step[TimerWidth-1:0];
            if (step[TimerWidth]) begin
              tick_d  = '0;
              phase_d = PH_IDLE;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
      OP_INIT: begin
        if (phase_q != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          char_wait_d = 1'b0;
          init_idx_d  = '0;
          tick_d      = '0;
          phase_d     = PH_POWER;
          if (power_q == '0) begin
            init_idx_d = 3'd1;
            sb_en      = 1'b1;
            sb_byte    = init_byte(3'd0);
          end
        end
      end
      OP_CMD: begin
        if (phase_q != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          char_wait_d = 1'b0;
          sb_en       = 1'b1;
          sb_byte     = pop_item_i.byte_value;
        end
      end
      default: begin
        if (phase_q != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          queued_d    = pop_item_i.byte_value;
          char_wait_d = 1'b1;
          sb_en       = 1'b1;
          sb_byte     = pop_item_i.cursor_code;
        end
      end
    endcase

    // A new byte starts with its high nibble and the enable line raised.
    if (sb_en) begin
      cur_byte_d = sb_byte;
      sel_d      = sb_rs;
      low_next_d = 1'b1;
      pin_d      = mirror4(sb_byte[7:4]);
      strobe_d   = 1'b1;
      tick_d     = '0;
      phase_d    = PH_PULSE;
    end
    if (sn_low) begin
      low_next_d = 1'b0;
      pin_d      = mirror4(cur_byte_q[3:0]);
      strobe_d   = 1'b1;
      tick_d     = '0;
      phase_d    = PH_PULSE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q     <= PulseReset;
      settle_q    <= SettleReset;
      power_q     <= PowerReset;
      clear_q     <= ClearReset;
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      cur_byte_q  <= '0;
      queued_q    <= '0;
      char_wait_q <= 1'b0;
      low_next_q  <= 1'b0;
      sel_q       <= 1'b0;
      strobe_q    <= 1'b0;
      init_idx_q  <= '0;
      pin_q       <= '0;
      out_valid_q <= 1'b0;
      rejected_q  <= 1'b0;
      busy_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_e'(cfg_index_i))
          CFG_PULSE:  pulse_q  <= cfg_wdata_i;
          CFG_SETTLE: settle_q <= cfg_wdata_i;
          CFG_POWER:  power_q  <= cfg_wdata_i;
          default:    clear_q  <= cfg_wdata_i;
        endcase
      end
      if (pop) begin
        phase_q     <= phase_d;
        tick_q      <= tick_d;
        cur_byte_q  <= cur_byte_d;
        queued_q    <= queued_d;
        char_wait_q <= char_wait_d;
        low_next_q  <= low_next_d;
        sel_q       <= sel_d;
        strobe_q    <= strobe_d;
        init_idx_q  <= init_idx_d;
        pin_q       <= pin_d;
        rejected_q  <= rej;
        busy_q      <= (phase_d != PH_IDLE);
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The pin state registers double as the result register.
  assign out_valid_o  = out_valid_q;
  assign data_pins_o  = pin_q;
  assign reg_select_o = sel_q;
  assign enable_o     = strobe_q;
  assign busy_res_o   = busy_q;
  assign rejected_o   = rejected_q;

endmodule

// ===== verif/char_lcd_nibble_write_sequencer_checker.sv =====
// Checker that predicts and compares every result of the LCD nibble write sequencer.
`timescale 1ns / 1ps
module char_lcd_nibble_write_sequencer_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [clnws_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [clnws_pkg::CfgWidth-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [7:0]                          byte_value_i,
  input  logic [7:0]                          cursor_code_i,
  input  logic                                out_valid_o,
  input  logic                                out_stall_i,
  input  logic [3:0]                          data_pins_o,
  input  logic                                reg_select_o,
  input  logic                                read_write_o,
  input  logic                                enable_o,
  input  logic                                busy_res_o,
  input  logic                                rejected_o,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import clnws_pkg::*;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_POWER,
    SEQ_PULSE,
    SEQ_SETTLE,
    SEQ_CLEAR
  } seq_phase_e;

  typedef struct packed {
    logic [3:0] pins;
    logic       rs;
    logic       rw;
    logic       en;
    logic       busy;
    logic       rej;
  } pin_state_t;

  localparam logic [39:0] PowerUpBytes = 40'h33_32_28_0C_01;

  seq_phase_e              seq_phase;
  logic [TimerWidth-1:0]   tick_cnt;
  logic [7:0]              byte_now;
  logic [7:0]              char_byte;
  logic                    char_pending;
  logic                    low_half_next;
  logic                    rs_level;
  logic                    strobe;
  logic [2:0]              init_step;
  logic [3:0]              pins;
  logic [CfgWidth-1:0]     pulse_lim;
  logic [CfgWidth-1:0]     settle_lim;
  logic [CfgWidth-1:0]     power_lim;
  logic [CfgWidth-1:0]     clear_lim;

  pin_state_t expected_pins_q[$];
  int         mismatches = 0;
  int         pending_cnt = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_cnt;

  function automatic logic [7:0] power_up_byte(input logic [2:0] idx);
    return PowerUpBytes[8*(4-idx) +: 8];
  endfunction

  function automatic logic [3:0] flip_nibble(input logic [3:0] n);
    logic [3:0] r;
    for (int k = 0; k < 4; k++) r[k] = n[3-k];
    return r;
  endfunction

  // One tick of the wait counter; the counter stops at its largest value.
  function automatic bit count_reaches(input logic [CfgWidth-1:0] limit, input bit at_least_one);
    logic [31:0] lim;
    lim = (32'(limit) > CountMax) ? CountMax : 32'(limit);
    if (at_least_one && lim == 0) lim = 1;
    if (32'(tick_cnt) < CountMax) tick_cnt = tick_cnt + 1'b1;
    return 32'(tick_cnt) >= lim;
  endfunction

  function automatic void start_nibble(input logic [3:0] n);
    pins      = flip_nibble(n);
    strobe    = 1'b1;
    tick_cnt  = '0;
    seq_phase = SEQ_PULSE;
  endfunction

  function automatic void start_byte(input logic [7:0] b, input logic rs);
    byte_now      = b;
    rs_level      = rs;
    low_half_next = 1'b1;
    start_nibble(b[7:4]);
  endfunction

  function automatic void begin_power_up();
    init_step = 3'd1;
    start_byte(power_up_byte(3'd0), 1'b0);
  endfunction

  // A queued character follows its cursor byte, and the power-up list runs to its end.
  function automatic void byte_finished();
    if (char_pending) begin
      char_pending = 1'b0;
      start_byte(char_byte, 1'b1);
    end else if (init_step >= 3'd1 && init_step <= 3'd4) begin
      start_byte(power_up_byte(init_step), 1'b0);
      init_step = init_step + 3'd1;
    end else if (init_step >= 3'd5) begin
      init_step = '0;
      tick_cnt  = '0;
      seq_phase = (clear_lim == '0) ? SEQ_IDLE : SEQ_CLEAR;
    end else begin
      seq_phase = SEQ_IDLE;
    end
  endfunction

  function automatic void apply_tick();
    case (seq_phase)
      SEQ_POWER: begin
        if (count_reaches(power_lim, 1'b0)) begin_power_up();
      end
      SEQ_PULSE: begin
        if (count_reaches(pulse_lim, 1'b1)) begin
          strobe    = 1'b0;
          tick_cnt  = '0;
          seq_phase = SEQ_SETTLE;
        end
      end
      SEQ_SETTLE: begin
        if (count_reaches(settle_lim, 1'b1)) begin
          if (low_half_next) begin
            low_half_next = 1'b0;
            start_nibble(byte_now[3:0]);
          end else begin
            byte_finished();
          end
        end
      end
      SEQ_CLEAR: begin
        if (count_reaches(clear_lim, 1'b0)) begin
          tick_cnt  = '0;
          seq_phase = SEQ_IDLE;
        end
      end
      default: seq_phase = SEQ_IDLE;
    endcase
  endfunction

  function automatic pin_state_t predict_pins(input op_e op, input logic [7:0] value,
                                              input logic [7:0] cursor);
    pin_state_t r;
    bit         was_busy;
    was_busy = (seq_phase != SEQ_IDLE);
    r.rej    = 1'b0;
    if (op == OP_TICK) begin
      apply_tick();
    end else if (was_busy) begin
      r.rej = 1'b1;
    end else if (op == OP_INIT) begin
      char_pending = 1'b0;
      init_step    = '0;
      tick_cnt     = '0;
      seq_phase    = SEQ_POWER;
      if (power_lim == '0) begin_power_up();
    end else if (op == OP_CMD) begin
      char_pending = 1'b0;
      start_byte(value, 1'b0);
    end else begin
      char_byte    = value;
      char_pending = 1'b1;
      start_byte(cursor, 1'b0);
    end
    r.pins = pins;
    r.rs   = rs_level;
    r.rw   = 1'b0;
    r.en   = strobe;
    r.busy = (seq_phase != SEQ_IDLE);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [3:0] want,
                                      input logic [3:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pin_state_t want;
    if (!rst_ni) begin
      seq_phase     = SEQ_IDLE;
      tick_cnt      = '0;
      byte_now      = '0;
      char_byte     = '0;
      char_pending  = 1'b0;
      low_half_next = 1'b0;
      rs_level      = 1'b0;
      strobe        = 1'b0;
      init_step     = '0;
      pins          = '0;
      pulse_lim     = PulseReset;
      settle_lim    = SettleReset;
      power_lim     = PowerReset;
      clear_lim     = ClearReset;
      expected_pins_q.delete();
      pending_cnt <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_PULSE:  pulse_lim  = cfg_wdata_i;
          CFG_SETTLE: settle_lim = cfg_wdata_i;
          CFG_POWER:  power_lim  = cfg_wdata_i;
          CFG_CLEAR:  clear_lim  = cfg_wdata_i;
          default:    ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        expected_pins_q.push_back(predict_pins(op_e'(command_i), byte_value_i, cursor_code_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_pins_q.size() == 0) begin
          $error("result transfer with no expected pin state waiting");
          mismatches++;
        end else begin
          want = expected_pins_q.pop_front();
          check_field("data_pins", want.pins, data_pins_o);
          check_field("reg_select", 4'(want.rs), 4'(reg_select_o));
          check_field("read_write", 4'(want.rw), 4'(read_write_o));
          check_field("enable", 4'(want.en), 4'(enable_o));
          check_field("busy_res", 4'(want.busy), 4'(busy_res_o));
          check_field("rejected", 4'(want.rej), 4'(rejected_o));
        end
      end
      pending_cnt <= expected_pins_q.size();
    end
  end

endmodule

// ===== verif/char_lcd_nibble_write_sequencer_tb.sv =====
// Testbench top: clock, reset, request and tick stimulus, and the final verdict.
`timescale 1ns / 1ps
module char_lcd_nibble_write_sequencer_tb;
  import clnws_pkg::*;

  localparam int CycleLimit = 600000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CfgIndexWidth-1:0] cfg_index_i;
  logic [CfgWidth-1:0]      cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [1:0]               command_i;
  logic [7:0]               byte_value_i;
  logic [7:0]               cursor_code_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [3:0]               data_pins_o;
  logic                     reg_select_o;
  logic                     read_write_o;
  logic                     enable_o;
  logic                     busy_res_o;
  logic                     rejected_o;
  int                       fail_count;
  int                       pending;

  bit idle_on = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_off_done = 1'b0;

  char_lcd_nibble_write_sequencer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .byte_value_i (byte_value_i),
    .cursor_code_i(cursor_code_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_pins_o  (data_pins_o),
    .reg_select_o (reg_select_o),
    .read_write_o (read_write_o),
    .enable_o     (enable_o),
    .busy_res_o   (busy_res_o),
    .rejected_o   (rejected_o)
  );

  char_lcd_nibble_write_sequencer_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .byte_value_i (byte_value_i),
    .cursor_code_i(cursor_code_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_pins_o  (data_pins_o),
    .reg_select_o (reg_select_o),
    .read_write_o (read_write_o),
    .enable_o     (enable_o),
    .busy_res_o   (busy_res_o),
    .rejected_o   (rejected_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic send_request(input op_e op, input logic [7:0] value,
                              input logic [7:0] cursor);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= op;
    byte_value_i  <= value;
    cursor_code_i <= cursor;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_request(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Mostly ticks, so that started sequences run to their end between requests.
  task automatic send_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 72)
      send_request(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    else if (pick < 82)
      send_request(OP_CMD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    else if (pick < 92)
      send_request(OP_CHAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    else
      send_request(OP_INIT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic settle_pipeline();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [CfgWidth-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  task automatic write_timing(input logic [CfgWidth-1:0] pulse, input logic [CfgWidth-1:0] settle,
                              input logic [CfgWidth-1:0] power, input logic [CfgWidth-1:0] clear);
    write_reg(CFG_PULSE, pulse);
    write_reg(CFG_SETTLE, settle);
    write_reg(CFG_POWER, power);
    write_reg(CFG_CLEAR, clear);
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: short random stalls, plus one long hold-off that fills the block.
  initial begin : receiver
    int burst_left;
    int hold_left;
    burst_left  = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        hold_left     = 80;
        hold_off_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("char_lcd_nibble_write_sequencer: mismatch");
    $finish;
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_PULSE;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    command_i     = OP_TICK;
    byte_value_i  = '0;
    cursor_code_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;

    // Reset timing: a tick while idle, then a command whose long pulse rejects requests.
    send_request(OP_TICK, 8'h00, 8'h00);
    send_request(OP_CMD, 8'hFF, 8'h00);
    send_request(OP_INIT, 8'h00, 8'hFF);
    send_request(OP_CHAR, 8'h5A, 8'hC0);
    send_request(OP_CMD, 8'h00, 8'h00);
    send_ticks(3);

    // Shortening the timing in the middle of the pulse takes effect on the next tick.
    // Zero pulse and settle count as one tick; zero waits are skipped.
    settle_pipeline();
    write_timing(16'd0, 16'd0, 16'd0, 16'd0);
    send_ticks(6);
    send_request(OP_CMD, 8'h00, 8'h00);
    send_ticks(4);
    send_request(OP_CHAR, 8'hFF, 8'h80);
    send_ticks(10);
    send_request(OP_INIT, 8'h00, 8'h00);
    send_ticks(24);

    settle_pipeline();
    write_timing(16'd2, 16'd1, 16'd3, 16'd2);
    send_request(OP_INIT, 8'hA5, 8'h3C);
    send_request(OP_CHAR, 8'h41, 8'h80);
    send_ticks(50);

    // Largest settings: a few hundred ticks leave the power wait still running.
    settle_pipeline();
    write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    idle_on = 1'b0;
    send_request(OP_INIT, 8'h00, 8'h00);
    send_ticks(300);
    settle_pipeline();
    write_timing(16'd1, 16'd1, 16'd0, 16'd0);
    idle_on = 1'b1;
    send_ticks(30);

    for (int phase_idx = 0; phase_idx < 8; phase_idx++) begin
      settle_pipeline();
      if (phase_idx == 0)
        write_timing(16'd1, 16'd1, 16'd0, 16'd0);
      else
        write_timing(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                     16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)));
      if (phase_idx == 1) hold_off_req = 1'b1;
      if (phase_idx == 6) idle_on = 1'b0;
      repeat (150) send_random_item();
    end

    settle_pipeline();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("char_lcd_nibble_write_sequencer: match");
    end else begin
      $display("char_lcd_nibble_write_sequencer: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/clnws_pkg.sv
sv/clnws_front.sv
sv/clnws_fifo.sv
sv/clnws_back.sv
sv/char_lcd_nibble_write_sequencer.sv
verif/char_lcd_nibble_write_sequencer_checker.sv
verif/char_lcd_nibble_write_sequencer_tb.sv
